[sv/cbb_pkg.sv]
// Package for the clipped bitmap blitter: sizes, register codes, word types, clamp helpers.
package cbb_pkg;

  localparam int COORD_BITS = 12;
  localparam int ADDR_BITS  = 24;

  localparam int DIM_BITS   = COORD_BITS + 1;
  localparam int POS_BITS   = 14;
  localparam int PIXEL_BITS = 32;
  localparam int ALPHA_LSB  = 24;

  localparam int SUM_BITS =
    ((POS_BITS > COORD_BITS + 1) ? POS_BITS : COORD_BITS + 1) + 2;
  localparam int PROD_BITS = COORD_BITS + DIM_BITS;
  localparam int FULL_BITS = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (POS_BITS > DIM_BITS) ? POS_BITS : DIM_BITS;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;

  localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(1) << COORD_BITS;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET   = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET  = DIM_BITS'(480);
  localparam logic [DIM_BITS-1:0] BITMAP_WIDTH_RESET  = DIM_BITS'(64);
  localparam logic [DIM_BITS-1:0] BITMAP_HEIGHT_RESET = DIM_BITS'(64);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_BITMAP_WIDTH  = 3'd2,
    REG_BITMAP_HEIGHT = 3'd3,
    REG_POSITION_X    = 3'd4,
    REG_POSITION_Y    = 3'd5,
    REG_ALIGN_X       = 3'd6,
    REG_ALIGN_Y       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   frame_width;
    logic [DIM_BITS-1:0]   frame_height;
    logic [DIM_BITS-1:0]   bitmap_width;
    logic [DIM_BITS-1:0]   bitmap_height;
    logic [POS_BITS-1:0]   position_x;
    logic [POS_BITS-1:0]   position_y;
    logic [COORD_BITS-1:0] align_x;
    logic [COORD_BITS-1:0] align_y;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] source_pixel;
    logic                  start_of_image;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  dest_address;
    logic [PIXEL_BITS-1:0] dest_pixel;
    logic [COORD_BITS-1:0] dest_column;
    logic [COORD_BITS-1:0] dest_row;
  } out_word_t;

  // A visible pixel placed in the frame, handed from front to back.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } place_t;

  // Frame dimensions: anything above the largest frame acts as the largest.
  function automatic logic [DIM_BITS-1:0] clamp_frame(input logic [DIM_BITS-1:0] v);
    return (v > DIM_MAX) ? DIM_MAX : v;
  endfunction

  // Bitmap dimensions: also a zero size acts as one.
  function automatic logic [DIM_BITS-1:0] clamp_bitmap(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] d;
    d = (v > DIM_MAX) ? DIM_MAX : v;
    return (d == '0) ? DIM_BITS'(1) : d;
  endfunction

endpackage

[sv/cbb_front.sv]
// Front: source counters, frame placement, clip and alpha test.
module cbb_front (
  input  logic           clk,
  input  logic           rst,
  input  cbb_pkg::cfg_t  cfg,
  input  logic           accept,
  input  cbb_pkg::in_word_t in_word,
  output logic           place_push,
  output cbb_pkg::place_t place_word
);
  import cbb_pkg::*;

  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] column_next;
  logic [COORD_BITS-1:0] row_next;
  logic [COORD_BITS-1:0] cur_column;
  logic [COORD_BITS-1:0] cur_row;
  logic signed [SUM_BITS-1:0] x;
  logic signed [SUM_BITS-1:0] y;
  logic [DIM_BITS-1:0] fw;
  logic [DIM_BITS-1:0] fh;
  logic [DIM_BITS-1:0] bw;
  logic [DIM_BITS-1:0] bh;
  logic in_x;
  logic in_y;
  logic opaque;

  assign fw = clamp_frame(cfg.frame_width);
  assign fh = clamp_frame(cfg.frame_height);
  assign bw = clamp_bitmap(cfg.bitmap_width);
  assign bh = clamp_bitmap(cfg.bitmap_height);

  assign cur_column = in_word.start_of_image ? '0 : column;
  assign cur_row    = in_word.start_of_image ? '0 : row;

  assign x = $signed({{(SUM_BITS-POS_BITS){cfg.position_x[POS_BITS-1]}}, cfg.position_x})
           - $signed({{(SUM_BITS-COORD_BITS){1'b0}}, cfg.align_x})
           + $signed({{(SUM_BITS-COORD_BITS){1'b0}}, cur_column});
  assign y = $signed({{(SUM_BITS-POS_BITS){cfg.position_y[POS_BITS-1]}}, cfg.position_y})
           - $signed({{(SUM_BITS-COORD_BITS){1'b0}}, cfg.align_y})
           + $signed({{(SUM_BITS-COORD_BITS){1'b0}}, cur_row});

  assign in_x = !x[SUM_BITS-1] && (x < $signed({{(SUM_BITS-DIM_BITS){1'b0}}, fw}));
  assign in_y = !y[SUM_BITS-1] && (y < $signed({{(SUM_BITS-DIM_BITS){1'b0}}, fh}));
  assign opaque = |in_word.source_pixel[PIXEL_BITS-1:ALPHA_LSB];

  assign place_push        = accept && in_x && in_y && opaque;
  assign place_word.pixel  = in_word.source_pixel;
  assign place_word.column = x[COORD_BITS-1:0];
  assign place_word.row    = y[COORD_BITS-1:0];

  // raster advance; row wraps so the next image needs no start flag
  always_comb begin
    column_next = cur_column + COORD_BITS'(1);
    row_next    = cur_row;
    if (({1'b0, cur_column} + DIM_BITS'(1)) >= bw) begin
      column_next = '0;
      if (({1'b0, cur_row} + DIM_BITS'(1)) >= bh) begin
        row_next = '0;
      end else begin
        row_next = cur_row + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (accept) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

[sv/cbb_queue.sv]
// Short queue of placed pixels between front and back.
module cbb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  cbb_pkg::place_t wr_word,
  output logic            full,
  input  logic            rd,
  output cbb_pkg::place_t rd_word,
  output logic            empty
);
  import cbb_pkg::*;

  place_t entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign full    = (count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_word = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      if (rd) rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      if (wr && !rd) begin
        count <= count + (QUEUE_PTR_BITS+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (QUEUE_PTR_BITS+1)'(1);
      end
    end
  end

endmodule

[sv/cbb_back.sv]
// Back: row times pitch, address add, and the two-entry result buffer.
module cbb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [cbb_pkg::DIM_BITS-1:0] frame_width,
  input  logic             q_empty,
  input  cbb_pkg::place_t  q_word,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output cbb_pkg::out_word_t out_word
);
  import cbb_pkg::*;

  logic                 a_valid;
  logic [FULL_BITS-1:0] a_prod;
  place_t               a_place;
  logic                 a_load;
  logic [DIM_BITS-1:0]  fw;
  logic [FULL_BITS-1:0] addr_sum;

  out_word_t o_entries [2];
  logic      o_wr_ptr;
  logic      o_rd_ptr;
  logic [1:0] o_count;
  logic      o_push;
  logic      o_pop;
  out_word_t o_word;

  assign fw = clamp_frame(frame_width);

  assign o_push = a_valid && (o_count != 2'd2);
  assign o_pop  = pop && (o_count != 2'd0);
  assign a_load = !a_valid || o_push;
  assign q_pop  = a_load && !q_empty;

  assign addr_sum = a_prod + FULL_BITS'(a_place.column);

  assign o_word.dest_address = addr_sum[ADDR_BITS-1:0];
  assign o_word.dest_pixel   = a_place.pixel;
  assign o_word.dest_column  = a_place.column;
  assign o_word.dest_row     = a_place.row;

  assign empty    = (o_count == 2'd0);
  assign out_word = o_entries[o_rd_ptr];

  // multiply stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_prod  <= FULL_BITS'(q_word.row) * FULL_BITS'(fw);
      a_place <= q_word;
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      o_entries[o_wr_ptr] <= o_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      o_wr_ptr <= 1'b0;
      o_rd_ptr <= 1'b0;
      o_count  <= 2'd0;
    end else begin
      a_valid <= q_pop || (a_valid && !o_push);
      if (o_push) o_wr_ptr <= !o_wr_ptr;
      if (o_pop)  o_rd_ptr <= !o_rd_ptr;
      if (o_push && !o_pop) begin
        o_count <= o_count + 2'd1;
      end else if (o_pop && !o_push) begin
        o_count <= o_count - 2'd1;
      end
    end
  end

endmodule

[sv/clipped_bitmap_blit.sv]
// Top level of the clipped bitmap blitter with alpha test.
// A visible word accepted on the source side passes the queue write, the multiply
// stage and the result buffer, in that order, before it shows on the result side.
// Throughput: one source word per cycle; the front never waits on the back
// while the four-entry placement queue has room.
// Reset (synchronous): counters, queues and buffers empty, registers at defaults.
module clipped_bitmap_blit (
  input  logic                  clk,
  input  logic                  rst,
  // source words
  input  logic                  push,
  output logic                  full,
  input  cbb_pkg::in_word_t     in_word,
  // frame writes
  input  logic                  pop,
  output logic                  empty,
  output cbb_pkg::out_word_t    out_word,
  // register writes
  input  logic                  cfg_write,
  input  logic [cbb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cbb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import cbb_pkg::*;

  cfg_t   cfg;
  logic   accept;
  logic   place_push;
  place_t place_word;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  place_t q_word;

  // Every source word goes through the front, so the front stalls only when
  // the placement queue is full; transparent or clipped words leave no entry.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Register file. The user must write it only while the block is idle; the
  // block does not enforce this. Both halves read these registers live.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width   <= FRAME_WIDTH_RESET;
      cfg.frame_height  <= FRAME_HEIGHT_RESET;
      cfg.bitmap_width  <= BITMAP_WIDTH_RESET;
      cfg.bitmap_height <= BITMAP_HEIGHT_RESET;
      cfg.position_x    <= '0;
      cfg.position_y    <= '0;
      cfg.align_x       <= '0;
      cfg.align_y       <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data[DIM_BITS-1:0];
        REG_BITMAP_WIDTH:  cfg.bitmap_width  <= cfg_data[DIM_BITS-1:0];
        REG_BITMAP_HEIGHT: cfg.bitmap_height <= cfg_data[DIM_BITS-1:0];
        REG_POSITION_X:    cfg.position_x    <= cfg_data[POS_BITS-1:0];
        REG_POSITION_Y:    cfg.position_y    <= cfg_data[POS_BITS-1:0];
        REG_ALIGN_X:       cfg.align_x       <= cfg_data[COORD_BITS-1:0];
        REG_ALIGN_Y:       cfg.align_y       <= cfg_data[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: counts source coordinates, places and clips.
  cbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .in_word    (in_word),
    .place_push (place_push),
    .place_word (place_word)
  );

  // Decoupling queue between the halves.
  cbb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (place_push),
    .wr_word (place_word),
    .full    (q_full),
    .rd      (q_pop),
    .rd_word (q_word),
    .empty   (q_empty)
  );

  // Back: linear address and result buffer.
  cbb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_width (cfg.frame_width),
    .q_empty     (q_empty),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_word    (out_word)
  );

endmodule

[sv/cbb_checker.sv]
// Port-level checks for the clipped bitmap blitter, bound to the top level.
module cbb_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  full,
  input logic                  pop,
  input logic                  empty,
  input cbb_pkg::out_word_t    out_word
);
  import cbb_pkg::*;

  // out of reset the source side is open
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");

  // no frame write can appear sooner than the pipeline depth after reset
  a_reset_drain: assert property (@(posedge clk) rst |=> empty ##1 empty ##1 empty)
    else $error("word on result side too soon after reset");

  // transparent pixels never reach the frame
  a_opaque: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_word.dest_pixel[PIXEL_BITS-1:ALPHA_LSB] != '0))
    else $error("transparent pixel written");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting result changed");

endmodule

bind clipped_bitmap_blit cbb_checker u_cbb_checker (.*);

[tb/clipped_bitmap_blit_checker.sv]
// Checker for the clipped bitmap blitter: predicts frame writes and compares them.
module clipped_bitmap_blit_checker
  import cbb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  in_word_t                  in_word,
  input  logic                      pop,
  input  logic                      empty,
  input  out_word_t                 out_word,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        mismatches,
  output int                        pending,
  output int                        writes_checked
);

  cfg_t                  regs;
  logic [COORD_BITS-1:0] src_column;
  logic [COORD_BITS-1:0] src_row;
  out_word_t             expected_writes [$];

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: frame write %0d: %s", $realtime, writes_checked, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s is %h, predicted %h", name, got_v, want_v));
  endtask

  // sizes above 4096 act as 4096; floor covers the zero bitmap case
  function automatic int dim_limit(input logic [DIM_BITS-1:0] v, input int floor_v);
    int d;
    d = int'(v);
    if (d > 4096) d = 4096;
    if (d < floor_v) d = floor_v;
    return d;
  endfunction

  // frame write for one source pixel at the current source coordinate
  function automatic bit place_pixel(input logic [PIXEL_BITS-1:0] pixel,
                                     output out_word_t wr);
    int fw, fh, x, y, shift;
    fw = dim_limit(regs.frame_width, 0);
    fh = dim_limit(regs.frame_height, 0);
    x = int'($signed(regs.position_x));
    shift = int'(regs.align_x);
    x = x - shift + int'(src_column);
    y = int'($signed(regs.position_y));
    shift = int'(regs.align_y);
    y = y - shift + int'(src_row);
    wr = '0;
    if (x < 0 || x >= fw || y < 0 || y >= fh || pixel[PIXEL_BITS-1:ALPHA_LSB] == '0)
      return 1'b0;
    wr.dest_address = ADDR_BITS'(y * fw + x);
    wr.dest_pixel   = pixel;
    wr.dest_column  = COORD_BITS'(x);
    wr.dest_row     = COORD_BITS'(y);
    return 1'b1;
  endfunction

  // raster advance with wrap at the end of row and image
  task automatic advance_source();
    if (int'(src_column) + 1 >= dim_limit(regs.bitmap_width, 1)) begin
      src_column = '0;
      if (int'(src_row) + 1 >= dim_limit(regs.bitmap_height, 1))
        src_row = '0;
      else
        src_row = src_row + COORD_BITS'(1);
    end else begin
      src_column = src_column + COORD_BITS'(1);
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      regs.frame_width   = FRAME_WIDTH_RESET;
      regs.frame_height  = FRAME_HEIGHT_RESET;
      regs.bitmap_width  = BITMAP_WIDTH_RESET;
      regs.bitmap_height = BITMAP_HEIGHT_RESET;
      regs.position_x    = '0;
      regs.position_y    = '0;
      regs.align_x       = '0;
      regs.align_y       = '0;
      src_column         = '0;
      src_row            = '0;
      expected_writes.delete();
    end else begin
      if (pop && !empty) begin
        writes_checked++;
        if (expected_writes.size() == 0) begin
          report_mismatch("frame write with none predicted");
        end else begin
          want = expected_writes.pop_front();
          check_field("dest_address", 32'(out_word.dest_address), 32'(want.dest_address));
          check_field("dest_pixel", out_word.dest_pixel, want.dest_pixel);
          check_field("dest_column", 32'(out_word.dest_column), 32'(want.dest_column));
          check_field("dest_row", 32'(out_word.dest_row), 32'(want.dest_row));
        end
      end
      if (push && !full) begin
        if (in_word.start_of_image) begin
          src_column = '0;
          src_row    = '0;
        end
        if (place_pixel(in_word.source_pixel, want))
          expected_writes.push_back(want);
        advance_source();
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_FRAME_WIDTH:   regs.frame_width   = cfg_data[DIM_BITS-1:0];
          REG_FRAME_HEIGHT:  regs.frame_height  = cfg_data[DIM_BITS-1:0];
          REG_BITMAP_WIDTH:  regs.bitmap_width  = cfg_data[DIM_BITS-1:0];
          REG_BITMAP_HEIGHT: regs.bitmap_height = cfg_data[DIM_BITS-1:0];
          REG_POSITION_X:    regs.position_x    = cfg_data[POS_BITS-1:0];
          REG_POSITION_Y:    regs.position_y    = cfg_data[POS_BITS-1:0];
          REG_ALIGN_X:       regs.align_x       = cfg_data[COORD_BITS-1:0];
          REG_ALIGN_Y:       regs.align_y       = cfg_data[COORD_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
    pending <= expected_writes.size();
  end

endmodule

[tb/clipped_bitmap_blit_tb.sv]
// Testbench top for the clipped bitmap blitter: stimulus, idling and verdict.
module clipped_bitmap_blit_tb;
  import cbb_pkg::*;

  // stimulus stops once this many source words went in; idling ends near the tail
  localparam int ITEM_GOAL     = 1450;
  localparam int CALM_FROM     = 1250;
  // settling edges after the last predicted write, so a clipped word cannot still be inside
  localparam int SETTLE_CYCLES = 6;

  logic                      clk;
  logic                      rst;
  logic                      push;
  logic                      full;
  in_word_t                  in_word;
  logic                      pop;
  logic                      empty;
  out_word_t                 out_word;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int blit_errors;
  int writes_pending;
  int writes_checked;

  logic calm;           // no idling on either side once set
  int   words_sent;
  int   settings_used;
  int   image_w;        // source bitmap size in use, after clamping
  int   image_h;

  clipped_bitmap_blit u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .pop       (pop),
    .empty     (empty),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clipped_bitmap_blit_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .in_word        (in_word),
    .pop            (pop),
    .empty          (empty),
    .out_word       (out_word),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (blit_errors),
    .pending        (writes_pending),
    .writes_checked (writes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every word and every frame
  // write waiting out the longest stall burst, plus register loads and settling).
  initial begin
    #5000000;
    $display("clipped_bitmap_blit: mismatch");
    $finish;
  end

  // Frame write side: pop stays high except for random stall bursts.
  // Only one assignment to pop per edge, so a stall never glitches.
  initial begin
    pop = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // One source word; returns at the edge that took it. push stays high so a
  // back-to-back word needs no second assignment in the same step.
  task automatic send_word(input logic [PIXEL_BITS-1:0] pixel, input logic sof);
    push    <= 1'b1;
    in_word <= '{source_pixel: pixel, start_of_image: sof};
    do @(posedge clk); while (full);
    words_sent++;
    if (!calm && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Drain: first let the pending count include the last word taken, then wait
  // until every predicted write is seen, then long enough for a clipped word to
  // leave the pipe, so registers can change safely.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int dim_in_use(input int v, input int floor_v);
    int d;
    d = (v > 4096) ? 4096 : v;
    return (d < floor_v) ? floor_v : d;
  endfunction

  // Loads all eight registers back to back while the block is idle.
  // junk puts garbage in the cfg_data bits above each register's width.
  task automatic apply_setting(input int fw, input int fh, input int bw, input int bh,
                               input int px, input int py, input int ax, input int ay,
                               input bit junk);
    logic [CFG_DATA_BITS-1:0] reg_image [8];
    logic [CFG_DATA_BITS-1:0] spare;
    cfg_reg_t r;
    settle();
    spare = junk ? CFG_DATA_BITS'($urandom) : '0;
    reg_image[REG_FRAME_WIDTH]   = CFG_DATA_BITS'(fw) | {spare[13], 13'b0};
    reg_image[REG_FRAME_HEIGHT]  = CFG_DATA_BITS'(fh) | {spare[12], 13'b0};
    reg_image[REG_BITMAP_WIDTH]  = CFG_DATA_BITS'(bw) | {spare[11], 13'b0};
    reg_image[REG_BITMAP_HEIGHT] = CFG_DATA_BITS'(bh) | {spare[10], 13'b0};
    reg_image[REG_POSITION_X]    = CFG_DATA_BITS'(px);
    reg_image[REG_POSITION_Y]    = CFG_DATA_BITS'(py);
    reg_image[REG_ALIGN_X]       = CFG_DATA_BITS'(ax) | {spare[9:8], 12'b0};
    reg_image[REG_ALIGN_Y]       = CFG_DATA_BITS'(ay) | {spare[7:6], 12'b0};
    r = REG_FRAME_WIDTH;
    repeat (8) begin
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data  <= reg_image[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_write <= 1'b0;
    image_w = dim_in_use(bw, 1);
    image_h = dim_in_use(bh, 1);
    settings_used++;
  endtask

  function automatic logic [PIXEL_BITS-1:0] random_pixel();
    logic [PIXEL_BITS-1:0] p;
    p = $urandom;
    if ($urandom_range(0, 7) == 0) p[PIXEL_BITS-1:ALPHA_LSB] = '0;  // transparent
    return p;
  endfunction

  // Frame and bitmap sizes: mostly small, with zero and oversized values.
  function automatic int pick_frame_dim();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 8191;
      2:       return 4096;
      3:       return 4097;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  function automatic int pick_bitmap_dim();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 8191;
      2:       return 4096;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_align();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  // Anchor mostly straddles the near or far frame edge so that clipping
  // cuts through images; sometimes a wild value that clips everything.
  function automatic int pick_position(input int align, input int span, input int reach);
    int p;
    int edge_at;
    case ($urandom_range(0, 9))
      0:       return -8192;
      1:       return 8191;
      2:       return int'($urandom_range(0, 16383)) - 8192;
      default: begin
        edge_at = $urandom_range(0, 1) ? 0 : span;
        if (reach > 64) reach = 64;
        p = align + edge_at - int'($urandom_range(0, reach + 2)) + int'($urandom_range(0, 2));
        if (p > 8191) p = 8191;
        if (p < -8192) p = -8192;
        return p;
      end
    endcase
  endfunction

  // Random setting, then count words as whole images with random content.
  // Most images start with a start-of-image pulse; some rely on the wrap,
  // and a few are cut short or carry stray pulses.
  task automatic random_phase(input int count);
    int fw, fh, bw, bh, ax, ay, px, py;
    int left, len, k;
    bit sof_first, broken;
    fw = pick_frame_dim();
    fh = pick_frame_dim();
    bw = pick_bitmap_dim();
    bh = pick_bitmap_dim();
    ax = pick_align();
    ay = pick_align();
    px = pick_position(ax, dim_in_use(fw, 1), dim_in_use(bw, 1));
    py = pick_position(ay, dim_in_use(fh, 1), dim_in_use(bh, 1));
    apply_setting(fw, fh, bw, bh, px, py, ax, ay, $urandom_range(0, 3) == 0);
    left = count;
    while (left > 0) begin
      len = image_w * image_h;
      if (len > left) len = left;
      sof_first = ($urandom_range(0, 3) != 0);
      broken    = ($urandom_range(0, 9) == 0);
      if (broken) len = $urandom_range(1, len);
      for (k = 0; k < len; k++)
        send_word(random_pixel(),
                  (k == 0 && sof_first) || (broken && $urandom_range(0, 5) == 0));
      left -= len;
    end
  endtask

  initial begin
    int chunk;
    rst       = 1'b1;
    push      = 1'b0;
    in_word   = '0;
    cfg_write = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset (640x480 frame, anchor at origin): opaque,
    // transparent, smallest nonzero alpha, all-zero word, restart mid-row.
    image_w = 64;
    image_h = 64;
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h00FF_FFFF, 1'b0);
    send_word(32'h0100_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h7F12_3456, 1'b1);

    // Oversized frame acts as 4096: hits the last column and row, the top
    // address, and clips the column just past the frame.
    apply_setting(8191, 8191, 3, 2, 4094, 4094, 0, 0, 1'b0);
    send_word(32'hA5A5_5A5A, 1'b1);
    repeat (5) send_word(random_pixel() | 32'h0100_0000, 1'b0);

    // Zero frame width: nothing may come out.
    apply_setting(0, 5, 2, 2, 0, 0, 0, 0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    repeat (2) send_word(32'hFFFF_FFFF, 1'b0);

    // Zero bitmap size acts as 1x1; alignment pulls a large anchor back in.
    apply_setting(4, 4, 0, 0, 4097, 4097, 4095, 4095, 1'b0);
    send_word(32'h1234_5678, 1'b1);
    send_word(32'h00AB_CDEF, 1'b0);
    send_word(32'hFEDC_BA98, 1'b0);
    send_word(32'h0F0F_0F0F, 1'b0);

    // Most negative and most positive anchors: all clipped.
    apply_setting(4096, 4096, 2, 1, -8192, 8191, 0, 0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);

    // Random settings; the tail runs with no idling at all.
    while (words_sent < ITEM_GOAL) begin
      calm  = (words_sent >= CALM_FROM);
      chunk = $urandom_range(20, 80);
      if (chunk > ITEM_GOAL - words_sent) chunk = ITEM_GOAL - words_sent;
      random_phase(chunk);
    end

    settle();
    $display("%0d source words over %0d register settings; %0d frame writes checked",
             words_sent, settings_used + 1, writes_checked);
    if (blit_errors == 0)
      $display("clipped_bitmap_blit: match");
    else
      $display("clipped_bitmap_blit: mismatch");
    $finish;
  end

endmodule
